// File: design/ubsp_pkg.sv
// shared types and constants of the uniform b-spline evaluator
// no dependencies; imported by the evaluator and its checker
`default_nettype none

package ubsp_pkg;

  // default sizes
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_ORDER_DEF  = 3;

  // request commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ORDER  = 2'd0;
  localparam logic [1:0] REG_POINTS = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  // register reset values
  localparam logic [1:0]  ORDER_RST  = 2'd3;
  localparam logic [6:0]  POINTS_RST = 7'd4;
  localparam logic [31:0] SCALE_RST  = 32'h0001_0000;

  // reciprocal of three for 32-bit operands, used with a shift of 33
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPAN,
    ST_LOAD,
    ST_DRAIN,
    ST_BRD,
    ST_BMUL,
    ST_BWR
  } state_t;

endpackage

`default_nettype wire

// File: design/uniform_bspline_deboor_eval.sv
// uniform b-spline evaluator, de boor blends over a point memory and a scratch memory
// depends on ubsp_pkg
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------------
//  request   | start, busy               | in_cmd, in_point_index, in_coord_*, in_time_value
//  result    | out_valid (one cycle)     | out_pos_x, out_pos_y, out_pos_z, out_status
//  config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// a load request leaves busy low. an evaluation with a bad configuration answers
// on the next cycle without going busy. a good evaluation holds busy through one
// multiply state, one span state, p+1 point memory reads plus a drain, and a read,
// a multiply and a write state per de boor blend through the scratch memory. the
// result strobe comes with the fall of busy, and the next request can be taken in
// the cycle of that strobe.
// reset is synchronous; the point memory is not cleared. cfg_ready is always high.
`default_nettype none

module uniform_bspline_deboor_eval
  import ubsp_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               start,
  output      logic               busy,
  input  wire logic               in_cmd,
  input  wire logic [5:0]         in_point_index,
  input  wire logic signed [31:0] in_coord_x,
  input  wire logic signed [31:0] in_coord_y,
  input  wire logic signed [31:0] in_coord_z,
  input  wire logic [31:0]        in_time_value,
  // result channel
  output      logic               out_valid,
  output      logic signed [31:0] out_pos_x,
  output      logic signed [31:0] out_pos_y,
  output      logic signed [31:0] out_pos_z,
  output      logic               out_status,
  // configuration port
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SD = MAX_ORDER + 1;
  localparam int JW = $clog2(SD);

  // configuration registers
  logic [1:0]  spline_order_r;
  logic [6:0]  num_points_r;
  logic [31:0] time_scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spline_order_r <= ORDER_RST;
      num_points_r   <= POINTS_RST;
      time_scale_r   <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORDER:  spline_order_r <= cfg_data[1:0];
        REG_POINTS: num_points_r   <= cfg_data[6:0];
        REG_SCALE:  time_scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer registers
  state_t              state_r, state_nxt;
  logic [31:0]         time_r, time_nxt;
  logic [63:0]         prod_r, prod_nxt;
  logic [7:0]          base_r, base_nxt;
  logic [32:0]         f_r, f_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [1:0]          i_r, i_nxt;
  logic [1:0]          j_r, j_nxt;
  logic                ld_v_r, ld_v_nxt;
  logic [1:0]          ld_j_r, ld_j_nxt;
  logic [30:0]         alpha_r, alpha_nxt;
  logic [63:0]         mprod_r [3];
  logic [63:0]         mprod_nxt [3];
  logic                out_valid_r, out_valid_nxt;
  logic [95:0]         out_pos_r, out_pos_nxt;
  logic                out_status_r, out_status_nxt;

  // memories and their registered read data
  logic [95:0]   pt_mem [MAX_POINTS];
  logic [95:0]   pt_rd_r;
  logic [95:0]   scr_mem [SD];
  logic [95:0]   scr_a_r, scr_b_r;

  logic          accept;
  logic          cfg_bad;
  logic          pt_we;
  logic [AW-1:0] pt_wa;
  logic          pt_re;
  logic [AW-1:0] pt_ra;
  logic          scr_we;
  logic [JW-1:0] scr_wa;
  logic [95:0]   scr_wd;
  logic          scr_re;

  // span arithmetic
  logic [7:0]  p8, diff8, ipart8, ceil8, k8, fdiff8;
  logic [63:0] lim64, sat64;
  // blend weight arithmetic
  logic [1:0]  pj, dv;
  logic [34:0] num35;
  logic [31:0] y32;
  logic [63:0] recip64;
  // blend lane arithmetic
  logic signed [32:0] diff33 [3];
  logic signed [64:0] full65 [3];
  logic signed [63:0] sum64 [3];
  logic [95:0]        blend96;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign cfg_bad = (spline_order_r == 2'd0)
                || (32'(spline_order_r) > MAX_ORDER)
                || (num_points_r < ({5'b0, spline_order_r} + 7'd1))
                || (32'(num_points_r) > MAX_POINTS);

  // point memory write on a load request
  assign pt_we = accept && (in_cmd == CMD_LOAD) && (32'(in_point_index) < MAX_POINTS);
  assign pt_wa = AW'(in_point_index);

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= {in_coord_z, in_coord_y, in_coord_x};
    end
    if (pt_re) begin
      pt_rd_r <= pt_mem[pt_ra];
    end
  end

  // scratch memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_wa] <= scr_wd;
    end
    if (scr_re) begin
      scr_a_r <= scr_mem[JW'(j_r - 2'd1)];
      scr_b_r <= scr_mem[JW'(j_r)];
    end
  end

  // span, clamp and fraction from the scaled time
  always_comb begin
    p8     = {6'b0, spline_order_r};
    diff8  = {1'b0, num_points_r} - p8;
    lim64  = {24'b0, diff8, 32'b0};
    sat64  = (prod_r > lim64) ? lim64 : prod_r;
    ipart8 = p8 + sat64[39:32];
    ceil8  = ipart8 + {7'b0, (sat64[31:0] != 32'b0)};
    k8     = (ceil8 < (p8 + 8'd1)) ? p8 : (ceil8 - 8'd1);
    fdiff8 = ipart8 - k8;
  end

  // blend weight alpha = (f + p - j) / (p - i) in q1.30
  always_comb begin
    pj      = spline_order_r - j_r;
    dv      = spline_order_r - i_r;
    num35   = {2'b0, f_r} + {1'b0, pj, 32'b0};
    y32     = num35[33:2];
    recip64 = {32'b0, y32} * {32'b0, RECIP3};
  end

  // per-lane blend: a + alpha * (b - a), rounded half up
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff33[c] = $signed({scr_b_r[c*32+31], scr_b_r[c*32 +: 32]})
                - $signed({scr_a_r[c*32+31], scr_a_r[c*32 +: 32]});
      full65[c] = $signed(65'(diff33[c])) * $signed(65'({2'b0, alpha_r}));
      sum64[c]  = $signed({{2{scr_a_r[c*32+31]}}, scr_a_r[c*32 +: 32], 30'b0})
                + $signed(mprod_r[c]) + 64'sd536870912;
      blend96[c*32 +: 32] = sum64[c][61:30];
    end
  end

  // sequencer next state and outputs
  always_comb begin
    state_nxt      = state_r;
    time_nxt       = time_r;
    prod_nxt       = prod_r;
    base_nxt       = base_r;
    f_nxt          = f_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    ld_v_nxt       = 1'b0;
    ld_j_nxt       = ld_j_r;
    alpha_nxt      = alpha_r;
    mprod_nxt      = mprod_r;
    out_valid_nxt  = 1'b0;
    out_pos_nxt    = out_pos_r;
    out_status_nxt = out_status_r;
    pt_re          = 1'b0;
    pt_ra          = AW'(base_r + {6'b0, cnt_r});
    scr_re         = 1'b0;
    scr_we         = 1'b0;
    scr_wa         = JW'(ld_j_r);
    scr_wd         = pt_rd_r;

    // fill the scratch memory from the point read pipeline
    if (ld_v_r) begin
      scr_we = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_EVAL)) begin
          if (cfg_bad) begin
            out_valid_nxt  = 1'b1;
            out_pos_nxt    = 96'b0;
            out_status_nxt = STATUS_ERR;
          end else begin
            time_nxt  = in_time_value;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = {32'b0, time_r} * {32'b0, time_scale_r};
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        base_nxt  = k8 - p8;
        f_nxt     = {fdiff8[0], sat64[31:0]};
        cnt_nxt   = 2'd0;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        pt_re    = 1'b1;
        ld_v_nxt = 1'b1;
        ld_j_nxt = cnt_r;
        if (cnt_r == spline_order_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        i_nxt     = 2'd0;
        j_nxt     = spline_order_r;
        state_nxt = ST_BRD;
      end
      ST_BRD: begin
        scr_re = 1'b1;
        case (dv)
          2'd1:    alpha_nxt = num35[32:2];
          2'd2:    alpha_nxt = num35[33:3];
          default: alpha_nxt = recip64[63:33];
        endcase
        state_nxt = ST_BMUL;
      end
      ST_BMUL: begin
        for (int c = 0; c < 3; c++) begin
          mprod_nxt[c] = full65[c][63:0];
        end
        state_nxt = ST_BWR;
      end
      ST_BWR: begin
        scr_we = 1'b1;
        scr_wa = JW'(j_r);
        scr_wd = blend96;
        if (j_r == (i_r + 2'd1)) begin
          if ((i_r + 2'd1) == spline_order_r) begin
            out_valid_nxt  = 1'b1;
            out_pos_nxt    = blend96;
            out_status_nxt = STATUS_OK;
            state_nxt      = ST_IDLE;
          end else begin
            i_nxt     = i_r + 2'd1;
            j_nxt     = spline_order_r;
            state_nxt = ST_BRD;
          end
        end else begin
          j_nxt     = j_r - 2'd1;
          state_nxt = ST_BRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ld_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_v_r      <= ld_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    time_r       <= time_nxt;
    prod_r       <= prod_nxt;
    base_r       <= base_nxt;
    f_r          <= f_nxt;
    cnt_r        <= cnt_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    ld_j_r       <= ld_j_nxt;
    alpha_r      <= alpha_nxt;
    mprod_r      <= mprod_nxt;
    out_pos_r    <= out_pos_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_pos_x  = out_pos_r[31:0];
  assign out_pos_y  = out_pos_r[63:32];
  assign out_pos_z  = out_pos_r[95:64];
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// File: design/ubsp_chk.sv
// port-level checker for the uniform b-spline evaluator, with its bind
// depends on ubsp_pkg and on the evaluator's port names
`default_nettype none

module ubsp_chk
  import ubsp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               in_cmd,
  input wire logic               out_valid,
  input wire logic signed [31:0] out_pos_x,
  input wire logic signed [31:0] out_pos_y,
  input wire logic signed [31:0] out_pos_z,
  input wire logic               out_status
);

  // a load request never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LOAD) |=> !out_valid)
    else $error("result after load request");

  // an evaluation either goes busy or answers at once
  a_eval_reacts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_EVAL) |=> (busy || out_valid))
    else $error("evaluation request dropped");

  // the end of a busy period delivers its result
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_status == STATUS_OK))
    else $error("busy fell without result");

  // error results carry zero positions
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_ERR) |->
      (out_pos_x == 32'sd0 && out_pos_y == 32'sd0 && out_pos_z == 32'sd0))
    else $error("error result with nonzero position");

endmodule

bind uniform_bspline_deboor_eval ubsp_chk u_ubsp_chk (.*);

`default_nettype wire

// File: tb/uniform_bspline_deboor_eval_test.sv
// regression bench for the uniform b-spline evaluator: directed and random requests
// with an in-bench fixed-point de boor predictor; depends on ubsp_pkg and the evaluator
`timescale 1ns / 1ps

module uniform_bspline_deboor_eval_test;
  import ubsp_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint     WEIGHT_ONE = 64'sd1 << 30;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               status;
  } position_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_cmd;
  logic [5:0] in_point_index;
  logic signed [31:0] in_coord_x, in_coord_y, in_coord_z;
  logic [31:0] in_time_value;
  logic out_valid;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  // predictor state: configuration and control point copy
  logic [1:0]  cur_order;
  logic [6:0]  cur_points;
  logic [31:0] cur_scale;
  logic signed [31:0] ctrl_pts [64][3];

  position_t pending_positions[$];
  int mismatches;
  int idle_pct;

  uniform_bspline_deboor_eval u_top (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_point_index(in_point_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_time_value(in_time_value),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // convex blend of two coordinates, weight in q2.30, rounded half up
  function automatic logic signed [31:0] blend_coord(longint a, longint b, longint w);
    longint acc;
    acc = (WEIGHT_ONE - w) * a + w * b;
    return 32'(((acc + (64'sd1 <<< 29)) >>> 30));
  endfunction

  // expected position for an evaluation at time tv
  function automatic position_t predict_position(logic [31:0] tv);
    position_t res;
    longint unsigned prod, lim, u, ceil_u, f, num, weight;
    int unsigned p, k, i, j, c;
    longint pt [4][3];
    res = '0;
    p = 32'(cur_order);
    if (p < 1 || p > MAX_ORDER_DEF || cur_points < p + 1 || cur_points > MAX_POINTS_DEF) begin
      res.status = STATUS_ERR;
      return res;
    end
    prod = {32'd0, tv} * {32'd0, cur_scale};
    lim = longint'(cur_points - p) << 32;
    if (prod > lim) prod = lim;
    u = (longint'(p) << 32) + prod;
    ceil_u = (u >> 32) + ((u[31:0] != 0) ? 1 : 0);
    k = int'(ceil_u) - 1;
    if (ceil_u < p + 1) k = p;
    f = u - (longint'(k) << 32);
    for (j = 0; j <= p; j++)
      for (c = 0; c < 3; c++) pt[j][c] = longint'(ctrl_pts[(k - p + j) % 64][c]);
    for (i = 0; i < p; i++)
      for (j = p; j > i; j--) begin
        num = f + (longint'(p - j) << 32);
        weight = num / (longint'(p - i) * 4);
        for (c = 0; c < 3; c++)
          pt[j][c] = longint'(blend_coord(pt[j-1][c], pt[j][c], weight));
      end
    res.x = 32'(pt[p][0]);
    res.y = 32'(pt[p][1]);
    res.z = 32'(pt[p][2]);
    res.status = STATUS_OK;
    return res;
  endfunction

  // send one request, predict when it is accepted
  task automatic send_request(logic cmd, logic [5:0] idx, logic [31:0] cx, logic [31:0] cy,
                              logic [31:0] cz, logic [31:0] tv);
    bit taken;
    int gap;
    start <= 1'b1;
    in_cmd <= cmd;
    in_point_index <= idx;
    in_coord_x <= cx;
    in_coord_y <= cy;
    in_coord_z <= cz;
    in_time_value <= tv;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (cmd == CMD_LOAD) begin
      ctrl_pts[idx][0] = cx;
      ctrl_pts[idx][1] = cy;
      ctrl_pts[idx][2] = cz;
    end else begin
      pending_positions.push_back(predict_position(tv));
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every pending result, then let a load or error answer settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_positions.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORDER:  cur_order = data[1:0];
      REG_POINTS: cur_points = data[6:0];
      REG_SCALE:  cur_scale = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic eval_at(logic [31:0] tv);
    send_request(CMD_EVAL, 6'($urandom), $urandom, $urandom, $urandom, tv);
  endtask

  // fill every slot, extremes in the first ones
  task automatic test_load_all();
    send_request(CMD_LOAD, 6'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff);
    send_request(CMD_LOAD, 6'd1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
    send_request(CMD_LOAD, 6'd2, 32'h7fff_ffff, 32'h8000_0000, 32'h1, $urandom);
    for (int n = 3; n < 64; n++)
      send_request(CMD_LOAD, n[5:0], $urandom, $urandom, $urandom, $urandom);
    wait_idle();
  endtask

  // directed evaluations: time extremes, clamping, error configurations
  task automatic test_directed();
    eval_at(32'h0);
    eval_at(32'h0000_8000);
    eval_at(32'h0001_0000);
    eval_at(32'hffff_ffff);
    wait_idle();
    write_reg(REG_ORDER, 32'd1);
    write_reg(REG_POINTS, 32'd2);
    eval_at(32'h0000_4000);
    eval_at(32'hffff_ffff);
    wait_idle();
    write_reg(REG_ORDER, 32'd2);
    write_reg(REG_POINTS, 32'd64);
    write_reg(REG_SCALE, 32'hffff_ffff);
    eval_at(32'h0000_0001);
    eval_at(32'hffff_ffff);
    wait_idle();
    write_reg(REG_SCALE, 32'h0);
    eval_at(32'h1234_5678);
    wait_idle();
    write_reg(REG_SCALE, 32'h1);
    write_reg(REG_ORDER, 32'd3);
    eval_at(32'hffff_ffff);
    wait_idle();
    // too few points, order zero, too many points, ignored register
    write_reg(REG_POINTS, 32'd3);
    eval_at(32'h0001_0000);
    wait_idle();
    write_reg(REG_POINTS, 32'd65);
    eval_at(32'h0);
    wait_idle();
    write_reg(REG_POINTS, 32'd127);
    eval_at(32'h0);
    wait_idle();
    write_reg(REG_POINTS, 32'd10);
    write_reg(REG_ORDER, 32'd0);
    eval_at(32'h0002_0000);
    wait_idle();
    write_reg(REG_UNUSED, 32'hffff_ffff);
    write_reg(REG_ORDER, 32'd3);
    write_reg(REG_SCALE, 32'h0001_0000);
    eval_at(32'h0003_8000);
    wait_idle();
  endtask

  // random settings, mostly evaluations with some point reloads
  task automatic test_random();
    logic [31:0] tv, sc;
    logic [31:0] pts;
    for (int s = 0; s < 12; s++) begin
      idle_pct = (s < 4) ? 27 : (s < 8) ? 88 : 0;
      write_reg(REG_ORDER, ($urandom_range(15) == 0) ? 32'd0 : $urandom_range(1, 3));
      pts = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 64);
      if (s == 1) pts = 64;
      if (s == 2) pts = 2;
      write_reg(REG_POINTS, pts);
      case ($urandom_range(3))
        0: sc = $urandom;
        1: sc = 32'h0001_0000;
        default: sc = $urandom_range(1, 32'h0004_0000);
      endcase
      if (s == 3) sc = 32'hffff_ffff;
      if (s == 5) sc = 32'd1;
      write_reg(REG_SCALE, sc);
      write_reg(REG_UNUSED, $urandom);
      for (int n = 0; n < 145; n++) begin
        if ($urandom_range(4) == 0) begin
          send_request(CMD_LOAD, 6'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else begin
          // mostly times inside the curve at the current scale
          if ($urandom_range(3) == 0) tv = $urandom;
          else tv = 32'((64'd65 << 32) / {32'd0, cur_scale} * $urandom_range(0, 1000) / 1000);
          eval_at(tv);
        end
      end
      wait_idle();
    end
  endtask

  // result checker
  always @(negedge clk) begin
    position_t want;
    if (rst_n && out_valid) begin
      if (pending_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d y=%0d z=%0d status=%0d",
                   out_pos_x, out_pos_y, out_pos_z, out_status);
      end else begin
        want = pending_positions.pop_front();
        if (want.x !== out_pos_x || want.y !== out_pos_y || want.z !== out_pos_z ||
            want.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d z=%0d st=%0d got x=%0d y=%0d z=%0d st=%0d",
                     want.x, want.y, want.z, want.status,
                     out_pos_x, out_pos_y, out_pos_z, out_status);
        end
      end
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("uniform_bspline_deboor_eval regression: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_LOAD;
    in_point_index = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_time_value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORDER;
    cfg_data = '0;
    mismatches = 0;
    idle_pct = 27;
    cur_order = ORDER_RST;
    cur_points = POINTS_RST;
    cur_scale = SCALE_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_all();
    test_directed();
    test_random();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_positions.size() == 0) begin
      $display("uniform_bspline_deboor_eval regression: pass");
    end else begin
      $display("uniform_bspline_deboor_eval regression: fail");
    end
    $finish;
  end

endmodule
